// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sstg_pkg.sv =====
package sstg_pkg;

    // Audio and table dimensions
    localparam int SAMPLE_RATE      = 48000;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SAMPLE_WIDTH     = 16;
    localparam int FREQ_FRAC_BITS   = 8;

    // Phase runs modulo the sample rate in Hz with fraction bits
    localparam longint PHASE_MOD = longint'(SAMPLE_RATE) << FREQ_FRAC_BITS;
    localparam int     PHASE_W   = $clog2(PHASE_MOD);

    // Table index covers four quadrants
    localparam longint IDX_SCALE = 4 * SINE_TABLE_DEPTH;
    localparam int     IDX_W     = $clog2(IDX_SCALE);
    localparam int     OFF_W     = $clog2(SINE_TABLE_DEPTH);
    localparam int     ADDR_W    = OFF_W + 1;

    // Reciprocal of the modulus, scaled so the estimate is low by at most one
    localparam longint RECIP   = (IDX_SCALE << PHASE_W) / PHASE_MOD;
    localparam int     RECIP_W = $clog2(RECIP + 1);
    localparam int     PROD_W  = PHASE_W + RECIP_W;
    localparam int     CMP_W   = PHASE_W + IDX_W + 1;

    // Tone amplitude
    localparam int     AMP_W    = SAMPLE_WIDTH - 1;
    localparam longint TONE_AMP = (longint'(1) << AMP_W) - 1;

    // Frequency register; a single fold suffices while 2^FREQ_W < 2 * PHASE_MOD
    localparam int     FREQ_W     = 23;
    localparam longint FREQ_RESET = 256000;

    localparam logic [PHASE_W-1:0] PHASE_MOD_C    = PHASE_W'(PHASE_MOD);
    localparam logic [PHASE_W-1:0] FREQ_RESET_MOD = PHASE_W'(FREQ_RESET % PHASE_MOD);
    localparam logic [RECIP_W-1:0] RECIP_C        = RECIP_W'(RECIP);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = FREQ_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_BLOCK,
        CFG_ENABLE_LEFT,
        CFG_ENABLE_RIGHT,
        CFG_TONE_FREQ
    } cfg_reg_t;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef struct packed {
        sample_t left_in;
        sample_t right_in;
    } frame_t;

    typedef struct packed {
        sample_t left_out;
        sample_t right_out;
        logic    left_written;
        logic    right_written;
    } mix_t;

    // Stage enables and phase step from the top level to the phase unit
    typedef struct packed {
        logic adv0;
        logic adv1;
        logic step;
    } phase_ctrl_t;

    typedef logic [AMP_W-1:0] rom_arr_t [0:SINE_TABLE_DEPTH];

    // Taylor series in unsigned Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                               64'd110, 64'd156};

    // Build the quarter-wave table at elaboration
    function automatic rom_arr_t build_quarter_rom();
        rom_arr_t    rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        int          k;
        int          n;
        for (k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (n = 1; n <= 6; n++)
            begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
                if ((n & 1) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            v = (64'(sum) * 64'(TONE_AMP) + (64'd1 << 29)) >> 30;
            if (v > 64'(TONE_AMP))
            begin
                v = 64'(TONE_AMP);
            end
            rom[k] = AMP_W'(v);
        end
        return rom;
    endfunction

endpackage

// ===== rtl/sstg_phase.sv =====
module sstg_phase (
    input  logic                        clk,
    input  logic                        rst_n,
    input  sstg_pkg::phase_ctrl_t       ctrl,
    input  logic [sstg_pkg::PHASE_W-1:0] freq,
    output logic [sstg_pkg::IDX_W-1:0]   idx
);
    import sstg_pkg::*;

    logic [PHASE_W-1:0] phase_accum_reg;
    logic [PHASE_W-1:0] phase_accum_next;
    logic [PHASE_W:0]   phase_sum;
    logic [PROD_W-1:0]  est_prod;
    logic [PHASE_W-1:0] phase1_reg;
    logic [IDX_W-1:0]   est1_reg;
    logic [IDX_W:0]     est_up;
    logic [CMP_W-1:0]   bound;
    logic [CMP_W-1:0]   scaled;
    logic [IDX_W-1:0]   idx_next;
    logic [IDX_W-1:0]   idx_reg;

    // Advance the phase and fold it back below the modulus
    always_comb
    begin
        phase_sum = {1'b0, phase_accum_reg} + {1'b0, freq};
        if (phase_sum >= {1'b0, PHASE_MOD_C})
        begin
            phase_sum = phase_sum - {1'b0, PHASE_MOD_C};
        end
        phase_accum_next = ctrl.step ? phase_sum[PHASE_W-1:0] : phase_accum_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_accum_reg <= '0;
        end
        else
        begin
            phase_accum_reg <= phase_accum_next;
        end
    end

    // Estimate the table index by the reciprocal of the modulus
    assign est_prod = PROD_W'(phase_accum_reg) * PROD_W'(RECIP_C);

    always_ff @(posedge clk)
    begin
        if (ctrl.adv0)
        begin
            phase1_reg <= phase_accum_reg;
            est1_reg   <= est_prod[PHASE_W +: IDX_W];
        end
    end

    // Correct the estimate, which is low by at most one
    always_comb
    begin
        est_up   = {1'b0, est1_reg} + 1'b1;
        bound    = CMP_W'(est_up) * CMP_W'(PHASE_MOD_C);
        scaled   = {1'b0, phase1_reg, IDX_W'(0)};
        idx_next = (bound <= scaled) ? est_up[IDX_W-1:0] : est1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            idx_reg <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

// ===== rtl/sstg_sine_rom.sv =====
module sstg_sine_rom (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [sstg_pkg::IDX_W-1:0] idx,
    output sstg_pkg::sample_t          tone
);
    import sstg_pkg::*;

    localparam rom_arr_t QUARTER_ROM = build_quarter_rom();

    logic [1:0]        quad;
    logic [OFF_W-1:0]  off;
    logic [ADDR_W-1:0] addr;
    logic [AMP_W-1:0]  mag_reg;
    logic              neg_reg;
    logic [SAMPLE_WIDTH-1:0] mag_ext;

    // Mirror the offset in the second and fourth quadrants
    always_comb
    begin
        quad = idx[IDX_W-1 -: 2];
        off  = idx[OFF_W-1:0];
        if (quad[0])
        begin
            addr = ADDR_W'(SINE_TABLE_DEPTH) - {1'b0, off};
        end
        else
        begin
            addr = {1'b0, off};
        end
    end

    // Synchronous table read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mag_reg <= QUARTER_ROM[addr];
            neg_reg <= quad[1];
        end
    end

    // Negate in the lower half of the wave
    assign mag_ext = {1'b0, mag_reg};
    assign tone    = neg_reg ? sample_t'(SAMPLE_WIDTH'(0) - mag_ext) : sample_t'(mag_ext);

endmodule

// ===== rtl/stereo_sine_tone_generator_core.sv =====
// Stereo sine tone generator. Takes one frame per cycle unless stalled, and
// gives one result frame per accepted frame, in order, through the registers
// for the reciprocal estimate of the table index, for its correction, for the
// synchronous read of the 1025-entry quarter-wave table, and the output
// register. While the block and a channel are enabled, each enabled channel is
// replaced by the tone and the phase advances by tone_freq; otherwise the frame
// passes through and the phase holds. Stalls collapse bubbles stage by stage,
// so a frame is taken whenever any stage ahead of it has room. Write the
// configuration registers only while no frame is in flight.
module stereo_sine_tone_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            frame_valid,
    output logic                            frame_stall,
    input  sstg_pkg::frame_t                frame,
    output logic                            mix_valid,
    input  logic                            mix_stall,
    output sstg_pkg::mix_t                  mix,
    input  logic                            cfg_write,
    input  logic [sstg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sstg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sstg_pkg::*;

    logic               enable_block_reg;
    logic               enable_left_reg;
    logic               enable_right_reg;
    logic [PHASE_W-1:0] freq_reg;
    logic [PHASE_W-1:0] freq_wr;

    logic        adv0;
    logic        adv1;
    logic        adv2;
    logic        adv3;
    logic        accept;
    logic        active;
    phase_ctrl_t phase_ctrl;

    logic       v1_reg;
    logic       v2_reg;
    logic       v3_reg;
    logic       mix_valid_reg;
    frame_t     f1_reg;
    frame_t     f2_reg;
    frame_t     f3_reg;
    logic [1:0] w1_reg;
    logic [1:0] w2_reg;
    logic [1:0] w3_reg;
    mix_t       mix_reg;
    mix_t       mix_next;

    logic [IDX_W-1:0] idx;
    sample_t          tone;

    // Fold the written frequency below the modulus
    always_comb
    begin
        freq_wr = PHASE_W'(cfg_data);
        if (freq_wr >= PHASE_MOD_C)
        begin
            freq_wr = freq_wr - PHASE_MOD_C;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_block_reg <= 1'b0;
            enable_left_reg  <= 1'b0;
            enable_right_reg <= 1'b0;
            freq_reg         <= FREQ_RESET_MOD;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_ENABLE_BLOCK: enable_block_reg <= cfg_data[0];
                CFG_ENABLE_LEFT:  enable_left_reg  <= cfg_data[0];
                CFG_ENABLE_RIGHT: enable_right_reg <= cfg_data[0];
                CFG_TONE_FREQ:    freq_reg         <= freq_wr;
            endcase
        end
    end

    // Stage advance, filling bubbles
    always_comb
    begin
        adv3   = !mix_valid_reg || !mix_stall;
        adv2   = !v3_reg || adv3;
        adv1   = !v2_reg || adv2;
        adv0   = !v1_reg || adv1;
        accept = frame_valid && adv0;
        active = enable_block_reg && (enable_left_reg || enable_right_reg);
        phase_ctrl.adv0 = adv0;
        phase_ctrl.adv1 = adv1;
        phase_ctrl.step = accept && active;
    end

    assign frame_stall = !adv0;

    // Item valid pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v1_reg <= frame_valid;
            end
            if (adv1)
            begin
                v2_reg <= v1_reg;
            end
            if (adv2)
            begin
                v3_reg <= v2_reg;
            end
            if (adv3)
            begin
                mix_valid_reg <= v3_reg;
            end
        end
    end

    // Carry the input samples and channel selects alongside the index
    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            f1_reg <= frame;
            w1_reg <= {enable_block_reg && enable_left_reg,
                       enable_block_reg && enable_right_reg};
        end
        if (adv1)
        begin
            f2_reg <= f1_reg;
            w2_reg <= w1_reg;
        end
        if (adv2)
        begin
            f3_reg <= f2_reg;
            w3_reg <= w2_reg;
        end
    end

    sstg_phase u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (phase_ctrl),
        .freq  (freq_reg),
        .idx   (idx)
    );

    sstg_sine_rom u_rom (
        .clk   (clk),
        .rd_en (adv2),
        .idx   (idx),
        .tone  (tone)
    );

    // Select tone or pass-through per channel
    always_comb
    begin
        mix_next.left_out      = w3_reg[1] ? tone : f3_reg.left_in;
        mix_next.right_out     = w3_reg[0] ? tone : f3_reg.right_in;
        mix_next.left_written  = w3_reg[1];
        mix_next.right_written = w3_reg[0];
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix_valid = mix_valid_reg;
    assign mix       = mix_reg;

endmodule

// ===== rtl/sstg_checker.sv =====
`include "assert_macros.svh"

module sstg_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           mix_valid,
    input logic           mix_stall,
    input sstg_pkg::mix_t mix
);
    import sstg_pkg::*;

    // Hold a stalled result
    `ASSERT_NEXT(a_valid_held, clk, rst_n, mix_valid && mix_stall, mix_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_payload_held, clk, rst_n, mix_valid && mix_stall, $stable(mix), "stalled result changed")

    // Both channels carry the same tone sample
    `ASSERT_IMPLIES(a_same_tone, clk, rst_n, mix_valid && mix.left_written && mix.right_written, mix.left_out == mix.right_out, "channels disagree on tone")

    // Left-channel tone never takes the value one below the negative table amplitude
    `ASSERT_IMPLIES(a_tone_range, clk, rst_n, mix_valid && mix.left_written, mix.left_out != sample_t'(TONE_AMP + 1), "tone below negative amplitude")

endmodule

bind stereo_sine_tone_generator_core sstg_checker u_sstg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .mix_valid (mix_valid),
    .mix_stall (mix_stall),
    .mix       (mix)
);

// ===== tb/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sstg_pkg::*;

    localparam int          DEPTH    = SINE_TABLE_DEPTH;
    localparam longint      MODULUS  = PHASE_MOD;
    localparam int unsigned AMPL     = 32'(TONE_AMP);
    localparam int unsigned FREQ_MAX = (1 << FREQ_W) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  frame_valid = 1'b0;
    logic                  frame_stall;
    frame_t                frame = '0;
    logic                  mix_valid;
    logic                  mix_stall = 1'b0;
    mix_t                  mix;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Frames waiting to be offered, and results still owed by the block
    frame_t frames_todo[$];
    mix_t   mix_due[$];

    // Mirror of the block's registers and phase
    bit              en_block = 1'b0;
    bit              en_left = 1'b0;
    bit              en_right = 1'b0;
    bit [FREQ_W-1:0] tone_step = FREQ_W'(FREQ_RESET);
    longint unsigned phase_acc = 0;

    int unsigned quarter_wave [0:DEPTH];

    bit   frame_took = 1'b0;
    bit   quiet = 1'b0;
    int   hold_asked = 0;
    int   hold_given = 0;
    int   hold_cnt = 0;
    int   errors = 0;
    mix_t want;

    stereo_sine_tone_generator_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .mix_valid   (mix_valid),
        .mix_stall   (mix_stall),
        .mix         (mix),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Quarter-wave magnitude: Q30 Taylor series, rounded and saturated
    function automatic int unsigned sine_magnitude(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned v;
        longint          acc;
        int              n;
        x    = (longint'(k) * 64'd1686629713) / DEPTH;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (n = 1; n <= 6; n++)
        begin
            term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        v = (longint'(acc) * AMPL + (64'd1 << 29)) >> 30;
        if (v > AMPL)
        begin
            v = AMPL;
        end
        return int'(v);
    endfunction

    // Tone sample for a phase, by truncated index into four quadrants
    function automatic sample_t tone_at(longint unsigned ph);
        longint unsigned idx;
        int              quad;
        int              off;
        int              mag;
        idx  = ph * 4 * DEPTH / MODULUS;
        quad = int'((idx / DEPTH) % 4);
        off  = int'(idx % DEPTH);
        mag  = (quad % 2 == 0) ? quarter_wave[off] : quarter_wave[DEPTH - off];
        return sample_t'((quad >= 2) ? -mag : mag);
    endfunction

    // Result for one frame; advances the phase on active frames
    function automatic mix_t next_mix(frame_t f);
        mix_t    m;
        sample_t s;
        m.left_out      = f.left_in;
        m.right_out     = f.right_in;
        m.left_written  = 1'b0;
        m.right_written = 1'b0;
        if (en_block && (en_left || en_right))
        begin
            s = tone_at(phase_acc);
            if (en_left)
            begin
                m.left_out     = s;
                m.left_written = 1'b1;
            end
            if (en_right)
            begin
                m.right_out     = s;
                m.right_written = 1'b1;
            end
            phase_acc = (phase_acc + longint'(tone_step) % MODULUS) % MODULUS;
        end
        return m;
    endfunction

    function automatic void check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v,
                     got_v);
            errors++;
        end
    endfunction

    // Sample the handshakes: mirror register writes, predict and check items
    always @(posedge clk)
    begin
        frame_took <= rst_n && frame_valid && !frame_stall;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ENABLE_BLOCK: en_block = cfg_data[0];
                    CFG_ENABLE_LEFT:  en_left = cfg_data[0];
                    CFG_ENABLE_RIGHT: en_right = cfg_data[0];
                    CFG_TONE_FREQ:    tone_step = cfg_data[FREQ_W-1:0];
                    default:          ;
                endcase
            end
            if (frame_valid && !frame_stall)
            begin
                mix_due.push_back(next_mix(frame));
            end
            if (mix_valid && !mix_stall)
            begin
                if (mix_due.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got %h", $realtime, mix);
                    errors++;
                end
                else
                begin
                    want = mix_due.pop_front();
                    check_field("left_out", want.left_out, mix.left_out);
                    check_field("right_out", want.right_out, mix.right_out);
                    check_field("left_written", want.left_written, mix.left_written);
                    check_field("right_written", want.right_written, mix.right_written);
                end
            end
        end
    end

    // Offer frames from the queue; hold a stalled item, idle at random
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            frame_valid <= 1'b0;
        end
        else if (frame_valid && !frame_took)
        begin
            frame_valid <= 1'b1;
        end
        else if (frames_todo.size() != 0 && (quiet || $urandom_range(99) >= 26))
        begin
            frame       <= frames_todo.pop_front();
            frame_valid <= 1'b1;
        end
        else
        begin
            frame_valid <= 1'b0;
        end
    end

    // Stall the result side at random, or for a long counted stretch on request
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            mix_stall <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            mix_stall <= 1'b1;
            hold_cnt  <= hold_cnt - 1;
        end
        else if (hold_asked != hold_given)
        begin
            hold_given <= hold_given + 1;
            hold_cnt   <= 79;
            mix_stall  <= 1'b1;
        end
        else
        begin
            mix_stall <= !quiet && ($urandom_range(99) < 26);
        end
    end

    task automatic set_reg(cfg_reg_t r, int unsigned v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= CFG_DATA_W'(v);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // One-bit registers get random upper bits, which the block must ignore
    task automatic set_flag(cfg_reg_t r, bit b);
        set_reg(r, ($urandom_range(FREQ_MAX >> 1) << 1) | 32'(b));
    endtask

    task automatic queue_frame(int l, int r);
        frame_t f;
        f.left_in  = sample_t'(l);
        f.right_in = sample_t'(r);
        frames_todo.push_back(f);
    endtask

    function automatic int any_sample();
        case ($urandom_range(9))
            0:       return -32768;
            1:       return 32767;
            2:       return 0;
            default: return int'(sample_t'($urandom));
        endcase
    endfunction

    function automatic int unsigned any_freq();
        case ($urandom_range(7))
            0:       return 0;
            1:       return FREQ_MAX;
            2:       return int'(MODULUS / 2);
            3:       return int'(MODULUS / 4);
            4:       return $urandom_range(4000, 1);
            5:       return 256000;
            default: return $urandom_range(FREQ_MAX);
        endcase
    endfunction

    // Wait until every frame is taken and every result has come back
    task automatic drain();
        while (frames_todo.size() != 0 || frame_valid || mix_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
    endtask

    initial
    begin
        int k;
        int p;
        int i;
        for (k = 0; k <= DEPTH; k++)
        begin
            quarter_wave[k] = sine_magnitude(k);
        end
        repeat (12) @(posedge clk);
        #2 rst_n = 1'b1;
        @(posedge clk);

        // Reset settings: block off, frames pass straight through
        queue_frame(-32768, 32767);
        queue_frame(32767, -32768);
        queue_frame(0, -1);
        queue_frame(-1, 0);
        queue_frame(16'h5555, 16'hAAAA);
        drain();

        // Block on with no channel: still pass-through, phase holds
        set_flag(CFG_ENABLE_BLOCK, 1'b1);
        queue_frame(1234, -1234);
        queue_frame(-32768, -32768);
        drain();

        // Left only at the reset frequency; first tone sample is zero
        set_flag(CFG_ENABLE_LEFT, 1'b1);
        for (i = 0; i < 4; i++)
        begin
            queue_frame(any_sample(), any_sample());
        end
        drain();

        // Right only
        set_flag(CFG_ENABLE_LEFT, 1'b0);
        set_flag(CFG_ENABLE_RIGHT, 1'b1);
        for (i = 0; i < 3; i++)
        begin
            queue_frame(any_sample(), any_sample());
        end
        drain();

        // Both channels: zero step, largest step, half-turn step
        set_flag(CFG_ENABLE_LEFT, 1'b1);
        set_reg(CFG_TONE_FREQ, 0);
        queue_frame(7, -7);
        queue_frame(-32768, 32767);
        drain();
        set_reg(CFG_TONE_FREQ, FREQ_MAX);
        for (i = 0; i < 4; i++)
        begin
            queue_frame(any_sample(), any_sample());
        end
        drain();
        set_reg(CFG_TONE_FREQ, int'(MODULUS / 2));
        for (i = 0; i < 3; i++)
        begin
            queue_frame(any_sample(), any_sample());
        end
        drain();

        // Random settings, each followed by a burst of random frames
        for (p = 0; p < 17; p++)
        begin
            set_flag(CFG_ENABLE_BLOCK, $urandom_range(9) != 0);
            set_flag(CFG_ENABLE_LEFT, $urandom_range(1) == 1);
            set_flag(CFG_ENABLE_RIGHT, $urandom_range(1) == 1);
            set_reg(CFG_TONE_FREQ, any_freq());
            quiet = (p == 7);
            for (i = 0; i < 100; i++)
            begin
                queue_frame(any_sample(), any_sample());
            end
            if (p == 3 || p == 11)
            begin
                hold_asked++;
            end
            drain();
            quiet = 1'b0;
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && mix_due.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // Give up if the run hangs
    initial
    begin
        #2_000_000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/sstg_pkg.sv
rtl/sstg_phase.sv
rtl/sstg_sine_rom.sv
rtl/stereo_sine_tone_generator_core.sv
rtl/sstg_checker.sv
tb/tb.sv
